// ===== src/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants for the euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // angle width inside the cordic (units of 2^-16 rad)
  localparam int unsigned AngW = 20;
  // cordic x/y width: magnitudes stay well under 2^17
  localparam int unsigned CsW = 19;
  localparam int unsigned CordicSteps = 16;

  localparam logic signed [AngW-1:0] AngPi = 20'sd205887;
  localparam logic signed [AngW-1:0] AngHalfPi = 20'sd102944;
  localparam logic signed [CsW-1:0] CordicX0 = 19'sd39797;

  // atan(2^-i) in units of 2^-16 rad
  function automatic logic signed [AngW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      4'd0: v = 20'sd51472;
      4'd1: v = 20'sd30385;
      4'd2: v = 20'sd16055;
      4'd3: v = 20'sd8150;
      4'd4: v = 20'sd4091;
      4'd5: v = 20'sd2047;
      4'd6: v = 20'sd1024;
      4'd7: v = 20'sd512;
      4'd8: v = 20'sd256;
      4'd9: v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // cordic lane state travelling down the pipeline
  typedef struct packed {
    logic signed [CsW-1:0]  x;
    logic signed [CsW-1:0]  y;
    logic signed [AngW-1:0] z;
    logic                   neg;
  } cordic_lane_t;

endpackage

// ===== src/e2q_cordic.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode cordic: cosine and sine of half an angle; range
// reduction in stage 0, one rotation step per later stage, 17 in total.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic                            clk_i,
  input  logic signed [15:0]              angle_i,
  output logic signed [e2q_pkg::CsW-1:0]  cos_o,
  output logic signed [e2q_pkg::CsW-1:0]  sin_o
);

  localparam int unsigned N = e2q_pkg::CordicSteps;

  e2q_pkg::cordic_lane_t lane_q [N+1];
  e2q_pkg::cordic_lane_t pre_d;
  logic signed [e2q_pkg::AngW-1:0] z0;

  // half angle in 2^-16 rad and range reduction to +/- pi/2
  always_comb begin
    z0 = e2q_pkg::AngW'(angle_i) <<< 3;
    pre_d.x = e2q_pkg::CordicX0;
    pre_d.y = '0;
    pre_d.neg = 1'b0;
    pre_d.z = z0;
    if (z0 > e2q_pkg::AngHalfPi) begin
      pre_d.z = z0 - e2q_pkg::AngPi;
      pre_d.neg = 1'b1;
    end else if (z0 < -e2q_pkg::AngHalfPi) begin
      pre_d.z = z0 + e2q_pkg::AngPi;
      pre_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q[0] <= pre_d;
  end

  // one rotation step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    e2q_pkg::cordic_lane_t st_d;
    always_comb begin
      st_d.neg = lane_q[i].neg;
      if (lane_q[i].z >= 0) begin
        st_d.x = lane_q[i].x - (lane_q[i].y >>> i);
        st_d.y = lane_q[i].y + (lane_q[i].x >>> i);
        st_d.z = lane_q[i].z - e2q_pkg::atan_lut(4'(i));
      end else begin
        st_d.x = lane_q[i].x + (lane_q[i].y >>> i);
        st_d.y = lane_q[i].y - (lane_q[i].x >>> i);
        st_d.z = lane_q[i].z + e2q_pkg::atan_lut(4'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      lane_q[i+1] <= st_d;
    end
  end

  // quadrant sign fix
  assign cos_o = lane_q[N].neg ? -lane_q[N].x : lane_q[N].x;
  assign sin_o = lane_q[N].neg ? -lane_q[N].y : lane_q[N].y;

endmodule

// ===== src/euler_to_quaternion.sv =====
// From start to done_o: 17 cordic stages, then 4 product/sum/output stages.
// Throughput: one angle triple per cycle; busy is always low.
// The cordic rotation pipeline sets the latency; every stage is fully pipelined.
// Reset clears only the valid bits; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X euler angles (Q3.12 rad) to unit quaternion (Q1.14), pipelined.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  output logic               done_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);

  localparam int unsigned CsW = e2q_pkg::CsW;
  localparam int unsigned Lat = e2q_pkg::CordicSteps + 5;

  assign busy = 1'b0;

  // valid bits travel with the data
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  // three cordic lanes
  logic signed [CsW-1:0] cr, sr, cp, sp, cy, sy;
  e2q_cordic u_roll  (.clk_i, .angle_i(roll_angle_i),  .cos_o(cr), .sin_o(sr));
  e2q_cordic u_pitch (.clk_i, .angle_i(pitch_angle_i), .cos_o(cp), .sin_o(sp));
  e2q_cordic u_yaw   (.clk_i, .angle_i(yaw_angle_i),   .cos_o(cy), .sin_o(sy));

  // stage a: roll x pitch pair products (Q.32)
  logic signed [2*CsW-1:0] cc_q, ss_q, sc_q, cs_q;
  logic signed [CsW-1:0] cy_q, sy_q;
  always_ff @(posedge clk_i) begin
    cc_q <= cr * cp;
    ss_q <= sr * sp;
    sc_q <= sr * cp;
    cs_q <= cr * sp;
    cy_q <= cy;
    sy_q <= sy;
  end

  // stage b: triple products (Q.48)
  localparam int unsigned TW = 3*CsW;
  logic signed [TW-1:0] t_ccc_q, t_sss_q, t_scc_q, t_css_q;
  logic signed [TW-1:0] t_csc_q, t_scs_q, t_ccs_q, t_ssc_q;
  always_ff @(posedge clk_i) begin
    t_ccc_q <= cc_q * cy_q;
    t_sss_q <= ss_q * sy_q;
    t_scc_q <= sc_q * cy_q;
    t_css_q <= cs_q * sy_q;
    t_csc_q <= cs_q * cy_q;
    t_scs_q <= sc_q * sy_q;
    t_ccs_q <= cc_q * sy_q;
    t_ssc_q <= ss_q * cy_q;
  end

  // stage c: sums with rounding offset
  localparam logic signed [TW:0] RndOff = (TW+1)'(64'sd1 <<< 33);
  logic signed [TW:0] sw_q, sx_q, sy2_q, sz_q;
  always_ff @(posedge clk_i) begin
    sw_q  <= (TW+1)'(t_ccc_q) + (TW+1)'(t_sss_q) + RndOff;
    sx_q  <= (TW+1)'(t_scc_q) - (TW+1)'(t_css_q) + RndOff;
    sy2_q <= (TW+1)'(t_csc_q) + (TW+1)'(t_scs_q) + RndOff;
    sz_q  <= (TW+1)'(t_ccs_q) - (TW+1)'(t_ssc_q) + RndOff;
  end

  // shift and saturate to +/- one
  function automatic logic signed [15:0] sat_q14(input logic signed [TW:0] v);
    logic signed [TW-34:0] r;
    r = v[TW:34];
    if (r > 16384) return 16'sd16384;
    if (r < -16384) return -16'sd16384;
    return 16'(r);
  endfunction

  // stage d: output register
  always_ff @(posedge clk_i) begin
    quat_w_o <= sat_q14(sw_q);
    quat_x_o <= sat_q14(sx_q);
    quat_y_o <= sat_q14(sy2_q);
    quat_z_o <= sat_q14(sz_q);
  end

  assign done_o = vld_q[Lat-1];

`ifndef SYNTH
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat))
    else $error("result without a transfer");
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_w_o <= 16'sd16384 && quat_w_o >= -16'sd16384))
    else $error("quat_w out of range");
`endif

endmodule

// ===== test/e2q_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// e2q_checker
// Watches the angle and quaternion channels of the converter, computes the
// expected quaternion for every accepted angle triple and compares results
// in order, field by field.
// ----------------------------------------------------------------------------
module e2q_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic               done_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  quat_t quat_q[$];

  localparam longint HalfPiU = 102944;
  localparam longint PiU = 205887;

  // atan(2^-i) in units of 2^-16 rad
  function automatic longint atan_step(input int i);
    longint steps [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
    return steps[i];
  endfunction

  // cosine and sine of half an angle, q.16
  function automatic void half_trig(input logic signed [15:0] ang, output longint c,
                                    output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 8;
    x = 39797;
    y = 0;
    flip = 0;
    if (z > HalfPiU) begin
      z -= PiU;
      flip = 1;
    end else if (z < -HalfPiU) begin
      z += PiU;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // q.48 to q1.14, round half up, saturate to +/-1
  function automatic logic signed [15:0] round_q14(input longint v);
    longint r;
    r = (v + (longint'(1) <<< 33)) >>> 34;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t zyx_quat(input logic signed [15:0] r,
                                     input logic signed [15:0] p,
                                     input logic signed [15:0] yw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_trig(r, cr, sr);
    half_trig(p, cp, sp);
    half_trig(yw, cy, sy);
    q.w = round_q14(cr * cp * cy + sr * sp * sy);
    q.x = round_q14(sr * cp * cy - cr * sp * sy);
    q.y = round_q14(cr * sp * cy + sr * cp * sy);
    q.z = round_q14(cr * cp * sy - sr * sp * cy);
    return q;
  endfunction

  assign pending_o = quat_q.size();

  // predict on every input transfer, compare on every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q;
    if (!rst_ni) begin
      errors_o <= 0;
      checked_o <= 0;
    end else begin
      if (done_i) begin
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                   quat_w_i, quat_x_i, quat_y_i, quat_z_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_q = quat_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_q.w !== quat_w_i || exp_q.x !== quat_x_i ||
              exp_q.y !== quat_y_i || exp_q.z !== quat_z_i) begin
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d,",
                     $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                     " got w=%0d x=%0d y=%0d z=%0d",
                     quat_w_i, quat_x_i, quat_y_i, quat_z_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      // queue the prediction for this transfer
      if (start_i && !busy_i)
        quat_q = {quat_q, zyx_quat(roll_angle_i, pitch_angle_i, yaw_angle_i)};
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives angle triples into the euler to quaternion converter: directed
// extremes first, then random triples with random idle bursts. The checker
// predicts and compares every quaternion result.
// ----------------------------------------------------------------------------
module tb;

  localparam int RandItems = 1650;
  localparam int Latency = 21;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] roll_angle_i = '0;
  logic signed [15:0] pitch_angle_i = '0;
  logic signed [15:0] yaw_angle_i = '0;
  logic done_o;
  logic signed [15:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  int errors, pending, checked;
  int sent = 0;

  always #1 clk_i = ~clk_i;

  euler_to_quaternion dut (
    .clk_i, .rst_ni, .start, .busy, .roll_angle_i, .pitch_angle_i, .yaw_angle_i,
    .done_o, .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o
  );

  e2q_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .roll_angle_i, .pitch_angle_i,
    .yaw_angle_i, .done_i(done_o), .quat_w_i(quat_w_o), .quat_x_i(quat_x_o),
    .quat_y_i(quat_y_o), .quat_z_i(quat_z_o), .errors_o(errors),
    .pending_o(pending), .checked_o(checked)
  );

  // one angle triple transfer; start stays high into the next call
  task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] yw);
    start <= 1'b1;
    roll_angle_i <= r;
    pitch_angle_i <= p;
    yaw_angle_i <= yw;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // angles near pi/2 and pi after halving, so both reduction branches fire
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(12868 + $urandom_range(0, 8) - 4);
      1: return 16'(-12868 + $urandom_range(0, 8) - 4);
      2: return 16'(25736 + $urandom_range(0, 8) - 4);
      3: return 16'(-25736 + $urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #100000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    logic [15:0] edge_vals [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                                   16'd6434, 16'd12868, 16'hcdbc};
    int gap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes on each axis and together
    for (int i = 0; i < 8; i++) send_angles(edge_vals[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, edge_vals[i], edge_vals[7 - i]);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h8000, 16'h5555);
    send_angles(16'haaaa, 16'h5555, 16'h8000);
    // random triples, idle bursts except in the last stretch
    for (int n = 0; n < RandItems; n++) begin
      if (n < RandItems - 200 && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk_i);
      end
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    $display("tb: %0d angle triples sent, %0d quaternions checked", sent, checked);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== euler_to_quaternion.f =====
src/e2q_pkg.sv
src/e2q_cordic.sv
src/euler_to_quaternion.sv
test/e2q_checker.sv
test/tb.sv
